[rtl/swsfr_pkg.sv]
// ----------------------------------------------------------------------------
// swsfr_pkg
// Types and constants for the single-wire sensor frame reader.
// ----------------------------------------------------------------------------
package swsfr_pkg;

  localparam int TICK_COUNTER_BITS_DEFAULT = 16;
  localparam int FRAME_BITS = 40;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_INDEX_BITS = 2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_START_LOW     = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RELEASE       = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TIMEOUT       = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ONE_THRESHOLD = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [15:0] START_LOW_RESET     = 16'd25000;
  localparam logic [7:0]  RELEASE_RESET       = 8'd30;
  localparam logic [7:0]  TIMEOUT_RESET       = 8'd99;
  localparam logic [7:0]  ONE_THRESHOLD_RESET = 8'd50;

  // Reading status codes.
  localparam logic [1:0] STAT_OK          = 2'd0;
  localparam logic [1:0] STAT_NO_RESPONSE = 2'd1;
  localparam logic [1:0] STAT_BIT_TIMEOUT = 2'd2;
  localparam logic [1:0] STAT_CHECKSUM    = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_START_LOW = 3'd1,
    PH_RELEASE   = 3'd2,
    PH_RESP_LOW  = 3'd3,
    PH_RESP_HIGH = 3'd4,
    PH_BIT_LOW   = 3'd5,
    PH_BIT_HIGH  = 3'd6
  } phase_t;

  typedef struct packed {
    logic start_request;
    logic line_level;
  } in_item_t;

  typedef struct packed {
    logic        drive_low;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  status;
    logic [15:0] humidity;
    logic [15:0] temperature;
  } out_item_t;

endpackage

[rtl/single_wire_sensor_frame_reader.sv]
// ----------------------------------------------------------------------------
// single_wire_sensor_frame_reader
// Host side of a single-wire temperature/humidity sensor read, one item per
// microsecond tick.
// ----------------------------------------------------------------------------
// Each input item is one tick with the sampled line level and a start request;
// each item yields exactly one result item. The block takes one item per clock
// cycle while the output is not stalled. An accepted item sits in an input
// register; once the result register is empty or being taken, the phase logic
// updates the reader state and writes the result register from that item. The
// input register lets an item be taken while the previous result still waits.
// Configuration is written through a plain write port; the user must write it
// only while idle, as the block itself does not enforce this.
module single_wire_sensor_frame_reader
  import swsfr_pkg::*;
#(
  parameter int TICK_COUNTER_BITS = TICK_COUNTER_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  in_item_t                  in_item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output out_item_t                 out_item,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int TW = TICK_COUNTER_BITS;
  localparam int CW = (TW > 16) ? TW : 16;
  localparam int BCW = $clog2(FRAME_BITS + 1);
  localparam logic [TW-1:0] TICK_MAX = {TW{1'b1}};

  logic [15:0] start_low_ticks;
  logic [7:0]  release_ticks;
  logic [7:0]  timeout_ticks;
  logic [7:0]  one_threshold_ticks;

  phase_t                phase, phase_next;
  logic [TW-1:0]         elapsed_ticks, elapsed_ticks_next;
  logic [BCW-1:0]        bit_count, bit_count_next;
  logic [FRAME_BITS-1:0] received_bits, received_bits_next;
  logic [15:0]           last_humidity, last_humidity_next;
  logic [15:0]           last_temperature, last_temperature_next;

  logic      s1_valid;
  in_item_t  s1_item;
  logic      advance;
  out_item_t res;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_low_ticks     <= START_LOW_RESET;
      release_ticks       <= RELEASE_RESET;
      timeout_ticks       <= TIMEOUT_RESET;
      one_threshold_ticks <= ONE_THRESHOLD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_START_LOW:     start_low_ticks     <= cfg_data;
        CFG_RELEASE:       release_ticks       <= cfg_data[7:0];
        CFG_TIMEOUT:       timeout_ticks       <= cfg_data[7:0];
        CFG_ONE_THRESHOLD: one_threshold_ticks <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Phase logic for one tick.
  always_comb begin
    phase_t          ph;
    logic [TW-1:0]   e;
    logic [TW-1:0]   e_inc;
    logic [CW-1:0]   start_ext;
    logic [CW-1:0]   start_clamp;
    logic [BCW-1:0]  cnt_inc;
    logic [FRAME_BITS-1:0] bits_shift;
    logic [7:0]      sum;
    logic            bit_val;
    logic            drive;
    logic            done;
    logic [1:0]      stat;

    phase_next            = phase;
    elapsed_ticks_next    = elapsed_ticks;
    bit_count_next        = bit_count;
    received_bits_next    = received_bits;
    last_humidity_next    = last_humidity;
    last_temperature_next = last_temperature;
    drive = 1'b0;
    done  = 1'b0;
    stat  = STAT_OK;

    // A start request while idle begins the hold phase on this same tick.
    if (phase == PH_IDLE && s1_item.start_request) begin
      ph = PH_START_LOW;
      e  = '0;
    end else begin
      ph = phase;
      e  = elapsed_ticks;
    end

    e_inc       = (e == TICK_MAX) ? e : e + TW'(1);
    start_ext   = CW'(start_low_ticks);
    start_clamp = (start_ext > CW'(TICK_MAX)) ? CW'(TICK_MAX) : start_ext;
    cnt_inc     = bit_count + BCW'(1);
    bit_val     = (e > TW'(one_threshold_ticks));
    bits_shift  = {received_bits[FRAME_BITS-2:0], bit_val};
    sum = bits_shift[39:32] + bits_shift[31:24] + bits_shift[23:16] + bits_shift[15:8];

    case (ph)
      PH_START_LOW: begin
        drive = 1'b1;
        if (CW'(e_inc) >= start_clamp) begin
          elapsed_ticks_next = '0;
          phase_next = (release_ticks == 8'd0) ? PH_RESP_LOW : PH_RELEASE;
        end else begin
          phase_next = PH_START_LOW;
          elapsed_ticks_next = e_inc;
        end
      end
      PH_RELEASE: begin
        if (e_inc >= TW'(release_ticks)) begin
          elapsed_ticks_next = '0;
          phase_next = PH_RESP_LOW;
        end else begin
          elapsed_ticks_next = e_inc;
        end
      end
      PH_RESP_LOW: begin
        if (s1_item.line_level) begin
          phase_next = PH_RESP_HIGH;
          elapsed_ticks_next = TW'(1);
        end else begin
          elapsed_ticks_next = e_inc;
        end
        if (elapsed_ticks_next > TW'(timeout_ticks)) begin
          done = 1'b1;
          stat = STAT_NO_RESPONSE;
        end
      end
      PH_RESP_HIGH: begin
        if (!s1_item.line_level) begin
          phase_next = PH_BIT_LOW;
          elapsed_ticks_next = TW'(1);
          bit_count_next = '0;
          received_bits_next = '0;
          if (TW'(1) > TW'(timeout_ticks)) begin
            done = 1'b1;
            stat = STAT_BIT_TIMEOUT;
          end
        end else begin
          elapsed_ticks_next = e_inc;
          if (e_inc > TW'(timeout_ticks)) begin
            done = 1'b1;
            stat = STAT_NO_RESPONSE;
          end
        end
      end
      PH_BIT_LOW: begin
        if (s1_item.line_level) begin
          phase_next = PH_BIT_HIGH;
          elapsed_ticks_next = TW'(1);
        end else begin
          elapsed_ticks_next = e_inc;
        end
        if (elapsed_ticks_next > TW'(timeout_ticks)) begin
          done = 1'b1;
          stat = STAT_BIT_TIMEOUT;
        end
      end
      PH_BIT_HIGH: begin
        if (s1_item.line_level) begin
          elapsed_ticks_next = e_inc;
          if (e_inc > TW'(timeout_ticks)) begin
            done = 1'b1;
            stat = STAT_BIT_TIMEOUT;
          end
        end else begin
          received_bits_next = bits_shift;
          bit_count_next = cnt_inc;
          if (cnt_inc == BCW'(16)) begin
            last_humidity_next = bits_shift[15:0];
          end
          if (cnt_inc == BCW'(32)) begin
            last_temperature_next = bits_shift[15:0];
          end
          if (cnt_inc >= BCW'(FRAME_BITS)) begin
            done = 1'b1;
            stat = (sum == bits_shift[7:0]) ? STAT_OK : STAT_CHECKSUM;
          end else begin
            phase_next = PH_BIT_LOW;
            elapsed_ticks_next = TW'(1);
            if (TW'(1) > TW'(timeout_ticks)) begin
              done = 1'b1;
              stat = STAT_BIT_TIMEOUT;
            end
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    if (done) begin
      phase_next = PH_IDLE;
      elapsed_ticks_next = '0;
    end

    res.drive_low   = drive;
    res.busy_res    = (phase_next != PH_IDLE);
    res.done_res    = done;
    res.status      = stat;
    res.humidity    = last_humidity_next;
    res.temperature = last_temperature_next;
  end

  // Control and reader state.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid         <= 1'b0;
      out_valid        <= 1'b0;
      phase            <= PH_IDLE;
      elapsed_ticks    <= '0;
      bit_count        <= '0;
      received_bits    <= '0;
      last_humidity    <= '0;
      last_temperature <= '0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid        <= 1'b1;
        phase            <= phase_next;
        elapsed_ticks    <= elapsed_ticks_next;
        bit_count        <= bit_count_next;
        received_bits    <= received_bits_next;
        last_humidity    <= last_humidity_next;
        last_temperature <= last_temperature_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
    if (advance) begin
      out_item <= res;
    end
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.done_res |-> !out_item.busy_res)
    else $error("finished reading still reported busy");

  a_status_only_on_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.done_res |-> out_item.status == STAT_OK)
    else $error("nonzero status without a finished reading");

  a_drive_while_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.drive_low |-> out_item.busy_res)
    else $error("line driven low outside a reading");

  a_idle_counter_clear: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> elapsed_ticks == '0)
    else $error("tick counter not cleared while idle");

  a_bit_count_range: assert property (@(posedge clk) disable iff (rst)
    bit_count <= BCW'(FRAME_BITS))
    else $error("bit count beyond frame length");

endmodule

[sim/single_wire_sensor_frame_reader_checker.sv]
// ----------------------------------------------------------------------------
// single_wire_sensor_frame_reader_checker
// Watches both channels and the register port of the sensor frame reader. It
// keeps its own copy of the reader state and timing registers, works out the
// result of every accepted line tick, and compares each result field by field
// in order. Mismatches are counted and handed to the test top.
// ----------------------------------------------------------------------------
module single_wire_sensor_frame_reader_checker
  import swsfr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  in_item_t                  in_item,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  out_item_t                 out_item,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output int                        pending,
  output int                        fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [15:0] hold_len;
  logic [7:0]  gap_len;
  logic [7:0]  limit_len;
  logic [7:0]  one_len;

  phase_t                                phase;
  logic [TICK_COUNTER_BITS_DEFAULT-1:0]  elapsed;
  logic [5:0]                            bit_count;
  logic [FRAME_BITS-1:0]                 frame;
  logic [15:0]                           humidity_seen;
  logic [15:0]                           temperature_seen;

  out_item_t reader_outputs[$];
  int        mismatches = 0;

  assign fail_count = mismatches;

  // The tick counter saturates instead of wrapping.
  function automatic void count_tick();
    if (~&elapsed) elapsed = elapsed + 1'b1;
  endfunction

  function automatic out_item_t reader_tick(in_item_t tick);
    out_item_t  r;
    logic       drive;
    logic       done;
    logic [1:0] code;
    logic [7:0] sum;
    drive = 1'b0;
    done  = 1'b0;
    code  = STAT_OK;
    if (phase == PH_IDLE && tick.start_request) begin
      phase   = PH_START_LOW;
      elapsed = '0;
    end
    case (phase)
      PH_START_LOW: begin
        drive = 1'b1;
        count_tick();
        if (elapsed >= hold_len) begin
          elapsed = '0;
          phase   = (gap_len == 0) ? PH_RESP_LOW : PH_RELEASE;
        end
      end
      PH_RELEASE: begin
        count_tick();
        if (elapsed >= gap_len) begin
          elapsed = '0;
          phase   = PH_RESP_LOW;
        end
      end
      PH_RESP_LOW: begin
        if (tick.line_level) begin
          phase   = PH_RESP_HIGH;
          elapsed = 1;
        end else begin
          count_tick();
        end
        if (elapsed > limit_len) begin
          done = 1'b1;
          code = STAT_NO_RESPONSE;
        end
      end
      PH_RESP_HIGH: begin
        if (!tick.line_level) begin
          phase     = PH_BIT_LOW;
          elapsed   = 1;
          bit_count = '0;
          frame     = '0;
          if (elapsed > limit_len) begin
            done = 1'b1;
            code = STAT_BIT_TIMEOUT;
          end
        end else begin
          count_tick();
          if (elapsed > limit_len) begin
            done = 1'b1;
            code = STAT_NO_RESPONSE;
          end
        end
      end
      PH_BIT_LOW: begin
        if (tick.line_level) begin
          phase   = PH_BIT_HIGH;
          elapsed = 1;
        end else begin
          count_tick();
        end
        if (elapsed > limit_len) begin
          done = 1'b1;
          code = STAT_BIT_TIMEOUT;
        end
      end
      PH_BIT_HIGH: begin
        if (tick.line_level) begin
          count_tick();
          if (elapsed > limit_len) begin
            done = 1'b1;
            code = STAT_BIT_TIMEOUT;
          end
        end else begin
          // The falling edge closes the pulse and decides the bit.
          frame     = {frame[FRAME_BITS-2:0], elapsed > one_len};
          bit_count = bit_count + 1'b1;
          if (bit_count == 16) humidity_seen = frame[15:0];
          if (bit_count == 32) temperature_seen = frame[15:0];
          if (bit_count >= FRAME_BITS) begin
            sum  = frame[39:32] + frame[31:24] + frame[23:16] + frame[15:8];
            done = 1'b1;
            code = (sum == frame[7:0]) ? STAT_OK : STAT_CHECKSUM;
          end else begin
            phase   = PH_BIT_LOW;
            elapsed = 1;
            if (elapsed > limit_len) begin
              done = 1'b1;
              code = STAT_BIT_TIMEOUT;
            end
          end
        end
      end
      default: phase = PH_IDLE;
    endcase
    if (done) begin
      phase   = PH_IDLE;
      elapsed = '0;
    end
    r.drive_low   = drive;
    r.busy_res    = (phase != PH_IDLE);
    r.done_res    = done;
    r.status      = code;
    r.humidity    = humidity_seen;
    r.temperature = temperature_seen;
    return r;
  endfunction

  task automatic flag(input string field, input logic [15:0] want, input logic [15:0] got);
    $display("%0t ns: %s expected 0x%0h, actual 0x%0h", $time, field, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      hold_len         = START_LOW_RESET;
      gap_len          = RELEASE_RESET;
      limit_len        = TIMEOUT_RESET;
      one_len          = ONE_THRESHOLD_RESET;
      phase            = PH_IDLE;
      elapsed          = '0;
      bit_count        = '0;
      frame            = '0;
      humidity_seen    = '0;
      temperature_seen = '0;
      reader_outputs.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_START_LOW:     hold_len  = cfg_data;
          CFG_RELEASE:       gap_len   = cfg_data[7:0];
          CFG_TIMEOUT:       limit_len = cfg_data[7:0];
          CFG_ONE_THRESHOLD: one_len   = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) reader_outputs.push_back(reader_tick(in_item));
      if (out_valid && out_ready) begin
        if (reader_outputs.size() == 0) begin
          $display("%0t ns: result with no tick outstanding, actual %p", $time, out_item);
          mismatches++;
        end else begin
          want = reader_outputs.pop_front();
          if (out_item.drive_low !== want.drive_low)
            flag("drive_low", want.drive_low, out_item.drive_low);
          if (out_item.busy_res !== want.busy_res)
            flag("busy_res", want.busy_res, out_item.busy_res);
          if (out_item.done_res !== want.done_res)
            flag("done_res", want.done_res, out_item.done_res);
          if (out_item.status !== want.status)
            flag("status", want.status, out_item.status);
          if (out_item.humidity !== want.humidity)
            flag("humidity", want.humidity, out_item.humidity);
          if (out_item.temperature !== want.temperature)
            flag("temperature", want.temperature, out_item.temperature);
        end
      end
    end
    pending <= reader_outputs.size();
  end

endmodule

[sim/single_wire_sensor_frame_reader_test.sv]
// ----------------------------------------------------------------------------
// single_wire_sensor_frame_reader_test
// Plays the sensor side of single-wire readings into the frame reader: start
// requests, response phases and 40-bit frames with good and bad checksums,
// phases cut short by timeouts, and line noise, over several timing setups
// with short holds. Both channels stall at random. A separate checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module single_wire_sensor_frame_reader_test;
  timeunit 1ns;
  timeprecision 1ps;
  import swsfr_pkg::*;

  // Cycles with no item moving on either channel before the run is called hung.
  localparam int WATCHDOG_LIMIT = 1000;

  // Where a scripted reading is stretched past the timeout. Bit k is cut in its
  // low phase at CUT_BITS + 2k and in its high pulse one later.
  localparam int CUT_NONE      = -1;
  localparam int CUT_RESP_LOW  = 0;
  localparam int CUT_RESP_HIGH = 1;
  localparam int CUT_BITS      = 2;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  in_item_t                  in_item = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b1;
  out_item_t                 out_item;
  logic                      cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_START_LOW;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  int                        pending;
  int                        fail_count;

  int   hold_set = START_LOW_RESET;
  int   gap_set = RELEASE_RESET;
  int   limit_set = TIMEOUT_RESET;
  int   one_set = ONE_THRESHOLD_RESET;
  int   ticks_sent = 0;
  int   stall_left = 0;
  int   quiet_cycles = 0;
  int   done_count [4] = '{default: 0};
  logic calm = 1'b0;
  logic last_busy = 1'b0;

  single_wire_sensor_frame_reader uut (.*);

  single_wire_sensor_frame_reader_checker frame_check (.*);

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    if (rst || calm) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else if ($urandom_range(0, 15) == 0) begin
      stall_left <= $urandom_range(1, 19);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      last_busy <= out_item.busy_res;
      if (out_item.done_res) done_count[out_item.status] <= done_count[out_item.status] + 1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t ns: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_tick(input logic start, input logic level);
    if (!calm && $urandom_range(0, 11) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{start_request: start, line_level: level};
    do @(posedge clk); while (!in_ready);
    ticks_sent++;
  endtask

  // Start requests inside a reading must be ignored, so they are sprinkled in.
  task automatic hold_line(input logic level, input int count);
    repeat (count) send_tick($urandom_range(0, 3) == 0, level);
  endtask

  // Waits for every result, then runs out any reading still in progress.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    while (last_busy) begin
      send_tick(1'b0, 1'b0);
      in_valid <= 1'b0;
      do @(posedge clk); while (pending != 0);
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] reg_index, input int value);
    cfg_write <= 1'b1;
    cfg_index <= reg_index;
    cfg_data  <= value[CFG_DATA_BITS-1:0];
    case (reg_index)
      CFG_START_LOW: hold_set  = value;
      CFG_RELEASE:   gap_set   = value;
      CFG_TIMEOUT:   limit_set = value;
      default:       one_set   = value;
    endcase
    @(posedge clk);
  endtask

  task automatic set_timing(input int hold, input int gap, input int limit, input int one);
    settle();
    write_reg(CFG_START_LOW, hold);
    write_reg(CFG_RELEASE, gap);
    write_reg(CFG_TIMEOUT, limit);
    write_reg(CFG_ONE_THRESHOLD, one);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [FRAME_BITS-1:0] frame_bits(input logic sum_ok);
    logic [31:0] data;
    logic [7:0]  sum;
    data = $urandom;
    sum  = data[31:24] + data[23:16] + data[15:8] + data[7:0];
    if (!sum_ok) sum = sum ^ 8'($urandom_range(1, 255));
    return {data, sum};
  endfunction

  function automatic int short_ticks();
    return $urandom_range(1, (limit_set < 3) ? limit_set : 3);
  endfunction

  // High pulse length for one bit, sitting near the threshold on either side.
  // When the threshold is not below the timeout only zeros can be sent.
  function automatic int high_ticks(input logic one);
    int ceiling;
    ceiling = (one_set < limit_set) ? one_set : limit_set;
    if (one && one_set < limit_set)
      return $urandom_range(one_set + 1, (one_set + 3 < limit_set) ? one_set + 3 : limit_set);
    return $urandom_range((ceiling > 2) ? ceiling - 2 : 1, ceiling);
  endfunction

  // One reading as the sensor would answer it. A cut holds the line in one
  // phase for one tick more than the timeout allows, which ends the reading.
  task automatic read_frame(input logic [FRAME_BITS-1:0] bits, input int cut);
    int lead;
    lead = ((hold_set == 0) ? 1 : hold_set) + gap_set;
    send_tick(1'b1, $urandom_range(0, 1));
    repeat (lead - 1) send_tick($urandom_range(0, 3) == 0, $urandom_range(0, 1));
    if (cut == CUT_RESP_LOW) begin
      hold_line(1'b0, limit_set + 1);
      return;
    end
    hold_line(1'b0, short_ticks() - 1);
    if (cut == CUT_RESP_HIGH) begin
      hold_line(1'b1, limit_set + 1);
      return;
    end
    hold_line(1'b1, short_ticks());
    for (int k = 0; k < FRAME_BITS; k++) begin
      if (cut == CUT_BITS + 2 * k) begin
        hold_line(1'b0, limit_set + 1);
        return;
      end
      hold_line(1'b0, short_ticks());
      if (cut == CUT_BITS + 2 * k + 1) begin
        hold_line(1'b1, limit_set + 1);
        return;
      end
      hold_line(1'b1, high_ticks(bits[FRAME_BITS - 1 - k]));
    end
    hold_line(1'b0, 1);
  endtask

  task automatic random_reading();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      read_frame(frame_bits(pick < 52), CUT_NONE);
    end else if (pick < 90) begin
      read_frame(frame_bits(1'b1), $urandom_range(CUT_RESP_LOW, CUT_BITS + 2 * FRAME_BITS - 1));
    end else begin
      repeat ($urandom_range(5, 30)) send_tick($urandom_range(0, 7) == 0, $urandom_range(0, 1));
      settle();
    end
    repeat ($urandom_range(0, 2)) send_tick(1'b0, $urandom_range(0, 1));
  endtask

  task automatic random_phase(input int span);
    int stop_at;
    stop_at = ticks_sent + span;
    while (ticks_sent < stop_at) random_reading();
  endtask

  initial begin
    int limit;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Ticks with no reading running leave the outputs at their reset values.
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);

    // Short hold, everything else still at its reset value.
    settle();
    write_reg(CFG_START_LOW, 2);
    cfg_write <= 1'b0;
    read_frame(frame_bits(1'b1), CUT_RESP_LOW);

    // Zero hold acts as one tick; zero release goes straight to the response.
    set_timing(0, 0, 8, 1);
    // The byte-sum wraps past 255 before it is compared.
    read_frame({32'hFFFF_FFFF, 8'hFC}, CUT_NONE);
    // A timeout after 33 bits still publishes both partial fields.
    read_frame(frame_bits(1'b1), CUT_BITS + 2 * 33);

    // Tightest timeout with the longest threshold.
    set_timing(1, 20, 1, 255);
    repeat (2) random_reading();

    for (int p = 0; p < 2; p++) begin
      limit = $urandom_range(4, 10);
      set_timing($urandom_range(0, 6), $urandom_range(0, 6), limit, $urandom_range(1, limit + 1));
      calm <= (p == 1);
      random_phase(80);
    end

    settle();
    repeat (8) @(posedge clk);
    $display("Sent %0d line ticks over five timing setups with holds of zero to six ticks.",
             ticks_sent);
    $display("Readings ended: %0d ok, %0d no response, %0d bit timeout, %0d bad checksum.",
             done_count[STAT_OK], done_count[STAT_NO_RESPONSE],
             done_count[STAT_BIT_TIMEOUT], done_count[STAT_CHECKSUM]);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
